### src/wsr_pkg.sv
// wsr_pkg: shared types and constants for the word stack with roll
// operation codes, error codes, controller states and fixed port widths
// no dependencies
package wsr_pkg;

   // fixed widths of the request and response ports
   localparam int PORT_WORD_W    = 64;
   localparam int DEPTH_FIELD_W  = 9;
   localparam int ROLL_COUNT_W   = 8;

   // default sizing of the stack memory
   localparam int DEF_STACK_DEPTH = 256;
   localparam int DEF_WORD_BITS   = 64;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2,
      OP_ROLL = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ERR_OK        = 2'd0,
      ERR_OVERFLOW  = 2'd1,
      ERR_UNDERFLOW = 2'd2,
      ERR_ROLL_DEEP = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SHIFT,
      ST_PLACE,
      ST_FIN
   } state_type;

endpackage

### src/word_stack_with_roll.sv
// word_stack_with_roll: upward-growing stack of machine words with push, pop,
// peek and roll, held in one synchronous memory with a registered read
// depends on wsr_pkg
//
// usage
//  - request channel (req_valid / req_stall): operation, push_value, roll_count.
//    a request is taken when req_valid is high and req_stall is low. requests
//    are handled one at a time; req_stall is high while one is in progress
//  - response channel (rsp_valid / rsp_stall): exactly one response per request
//    carrying the word read (pop, peek), an error code and the depth after the
//    request. the response sits in an output register, so the next request is
//    taken while a finished response still waits on rsp_stall
//  - request steps: push, roll by zero and errored requests go from idle to
//    the finish state; pop and peek pass through load; roll by n (n >= 1)
//    through load, shift and place. the roll loop is set by the single memory
//    port pair: one read and one write of the word array per cycle
//  - a finished request waits in the finish state while the previous
//    response is still stalled
//  - reset (synchronous, active high) empties the stack and drops any held
//    response; the word memory itself is not cleared, entries are only read
//    below the current depth, where they were always written first
//  - an errored request (overflow, underflow, roll deeper than the stack)
//    leaves the stack unchanged and returns a zero word
module word_stack_with_roll
   import wsr_pkg::*;
#(
   parameter int STACK_DEPTH = DEF_STACK_DEPTH,
   parameter int WORD_BITS   = DEF_WORD_BITS
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_operation,
   input  logic [PORT_WORD_W-1:0]   req_push_value,
   input  logic [ROLL_COUNT_W-1:0]  req_roll_count,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [PORT_WORD_W-1:0]   rsp_read_word,
   output logic [1:0]               rsp_error_code,
   output logic [DEPTH_FIELD_W-1:0] rsp_depth_after
);

   // address width, count width (must hold STACK_DEPTH itself) and a compare
   // width wide enough for both the count and the roll distance
   localparam int AW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW     = $clog2(STACK_DEPTH + 1);
   localparam int CMP_W  = (CW > ROLL_COUNT_W) ? CW : ROLL_COUNT_W;

   // word memory, entry 0 is the bottom of the stack
   logic [WORD_BITS-1:0] mem [STACK_DEPTH];
   logic [WORD_BITS-1:0] mem_rdata_ff;
   logic                 mem_re;
   logic [AW-1:0]        mem_raddr;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;

   // control state
   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // per-request working registers
   op_type               op_ff, op_in;
   err_type              res_err_ff, res_err_in;
   logic [WORD_BITS-1:0] res_word_ff, res_word_in;
   logic [AW-1:0]        ptr_ff, ptr_in;
   logic [AW-1:0]        top_ff, top_in;
   logic [WORD_BITS-1:0] moved_ff, moved_in;

   // response register
   logic [WORD_BITS-1:0] rsp_word_ff, rsp_word_in;
   err_type              rsp_err_ff, rsp_err_in;
   logic [CW-1:0]        rsp_depth_ff, rsp_depth_in;

   // request decode
   logic                 req_acc;
   op_type               req_op;
   logic                 stack_full;
   logic                 stack_empty;
   logic                 roll_deep;
   logic [CMP_W-1:0]     cnt_ext;
   logic [CMP_W-1:0]     dist_ext;
   logic [AW-1:0]        top_addr;
   logic [AW-1:0]        from_addr;
   err_type              req_err;
   logic                 out_free;
   logic                 fin_now;
   logic                 rsp_load;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_acc     = req_valid && !req_stall;
   assign req_op      = op_type'(req_operation);
   assign stack_full  = (count_ff == CW'(STACK_DEPTH));
   assign stack_empty = (count_ff == '0);
   assign cnt_ext     = CMP_W'(count_ff);
   assign dist_ext    = CMP_W'(req_roll_count);
   assign roll_deep   = (dist_ext >= cnt_ext);
   assign top_addr    = AW'(count_ff - CW'(1));
   assign from_addr   = AW'(cnt_ext - CMP_W'(1) - dist_ext);

   always_comb begin
      case (req_op)
         OP_PUSH:          req_err = stack_full  ? ERR_OVERFLOW  : ERR_OK;
         OP_POP, OP_PEEK:  req_err = stack_empty ? ERR_UNDERFLOW : ERR_OK;
         OP_ROLL:          req_err = roll_deep   ? ERR_ROLL_DEEP : ERR_OK;
         default:          req_err = ERR_OK;
      endcase
   end

   // response handoff: the output register can take a new response when it
   // is empty or its current one leaves this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fin_now  = ((state_ff == ST_LOAD) && (op_ff != OP_ROLL))
                     || (state_ff == ST_PLACE) || (state_ff == ST_FIN);
   assign rsp_load = fin_now && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_err != ERR_OK || req_op == OP_PUSH) begin
                  state_in = ST_FIN;
               end else if (req_op == OP_ROLL && req_roll_count == '0) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            if (op_ff == OP_ROLL) begin
               state_in = ST_SHIFT;
            end else begin
               state_in = out_free ? ST_IDLE : ST_FIN;
            end
         end
         ST_SHIFT: begin
            if (ptr_ff == top_ff) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            state_in = out_free ? ST_IDLE : ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      mem_re       = 1'b0;
      mem_raddr    = ptr_ff;
      mem_we       = 1'b0;
      mem_waddr    = ptr_ff;
      mem_wdata    = mem_rdata_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      res_err_in   = res_err_ff;
      res_word_in  = res_word_ff;
      ptr_in       = ptr_ff;
      top_in       = top_ff;
      moved_in     = moved_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               op_in       = req_op;
               res_err_in  = req_err;
               res_word_in = '0;
               top_in      = top_addr;
               ptr_in      = from_addr;
               if (req_err == ERR_OK) begin
                  case (req_op)
                     OP_PUSH: begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(count_ff);
                        mem_wdata = req_push_value[WORD_BITS-1:0];
                        count_in  = count_ff + CW'(1);
                     end
                     OP_POP: begin
                        mem_re    = 1'b1;
                        mem_raddr = top_addr;
                        count_in  = count_ff - CW'(1);
                     end
                     OP_PEEK: begin
                        mem_re    = 1'b1;
                        mem_raddr = top_addr;
                     end
                     OP_ROLL: begin
                        mem_re    = 1'b1;
                        mem_raddr = from_addr;
                     end
                     default: ;
                  endcase
               end
            end
         end
         ST_LOAD: begin
            if (op_ff == OP_ROLL) begin
               // word leaving its place; start streaming the ones above it
               moved_in  = mem_rdata_ff;
               mem_re    = 1'b1;
               mem_raddr = ptr_ff + AW'(1);
               ptr_in    = ptr_ff + AW'(1);
            end else begin
               res_word_in = mem_rdata_ff;
            end
         end
         ST_SHIFT: begin
            // word read from ptr moves down one place
            mem_we    = 1'b1;
            mem_waddr = ptr_ff - AW'(1);
            mem_wdata = mem_rdata_ff;
            if (ptr_ff != top_ff) begin
               mem_re    = 1'b1;
               mem_raddr = ptr_ff + AW'(1);
               ptr_in    = ptr_ff + AW'(1);
            end
         end
         ST_PLACE: begin
            mem_we    = 1'b1;
            mem_waddr = top_ff;
            mem_wdata = moved_ff;
         end
         ST_FIN: ;
         default: ;
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_word_in  = rsp_word_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_depth_in = rsp_depth_ff;
      if (rsp_load) begin
         rsp_word_in  = (state_ff == ST_LOAD) ? mem_rdata_ff : res_word_ff;
         rsp_err_in   = res_err_ff;
         rsp_depth_in = count_ff;
      end
   end

   // word memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= mem[mem_raddr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      res_err_ff   <= res_err_in;
      res_word_ff  <= res_word_in;
      ptr_ff       <= ptr_in;
      top_ff       <= top_in;
      moved_ff     <= moved_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_depth_ff <= rsp_depth_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_word   = PORT_WORD_W'(rsp_word_ff);
   assign rsp_error_code  = rsp_err_ff;
   assign rsp_depth_after = DEPTH_FIELD_W'(rsp_depth_ff);

   // a successful push grows the stack by one
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_op == OP_PUSH && req_err == ERR_OK)
      |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("push did not grow the stack");

   // an errored request leaves the depth alone
   a_err_keeps_depth: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_err != ERR_OK) |=> $stable(count_ff))
      else $error("errored request changed the depth");

   // the depth only moves when a request is taken
   a_busy_keeps_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |=> $stable(count_ff))
      else $error("depth changed during a request");

   // the roll pointer never runs past the top word
   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (ptr_ff <= top_ff && ptr_ff != '0))
      else $error("roll pointer out of range");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for the word stack with roll (word_stack_with_roll)
// sends push, pop, peek and roll requests and checks each response against a stack predictor
// depends on wsr_pkg and word_stack_with_roll
module testbench;
   import wsr_pkg::*;

   localparam int STACK_DEPTH = DEF_STACK_DEPTH;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [1:0]               req_operation;
   logic [PORT_WORD_W-1:0]   req_push_value;
   logic [ROLL_COUNT_W-1:0]  req_roll_count;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [PORT_WORD_W-1:0]   rsp_read_word;
   logic [1:0]               rsp_error_code;
   logic [DEPTH_FIELD_W-1:0] rsp_depth_after;

   // one predicted response, tagged with the operation that caused it
   typedef struct packed {
      op_type                   op;
      logic [PORT_WORD_W-1:0]   word;
      err_type                  err;
      logic [DEPTH_FIELD_W-1:0] depth;
   } stack_reply_type;

   // responses still owed by the block, oldest first
   stack_reply_type        pending_replies[$];

   // predictor state: word array and current depth, entry 0 is the bottom
   logic [PORT_WORD_W-1:0] model_words [STACK_DEPTH];
   int                     model_depth;

   // when clear, neither side inserts gaps or stalls
   bit                     idle_on;

   int mismatch_count = 0;
   int request_count  = 0;
   int reply_count    = 0;
   int max_depth_seen = 0;
   int op_seen[4]     = '{default: 0};
   int err_seen[4]    = '{default: 0};

   word_stack_with_roll u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_push_value  (req_push_value),
      .req_roll_count  (req_roll_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_word   (rsp_read_word),
      .rsp_error_code  (rsp_error_code),
      .rsp_depth_after (rsp_depth_after)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #(20_000_000);
      $display("FAILURE");
      $finish;
   end

   // one line per mismatch
   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at response %0d: %s got %h expected %h",
               reply_count, what, got, want);
      mismatch_count++;
   endtask

   function automatic logic [PORT_WORD_W-1:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   // stack predictor: applies one request and returns the response it causes
   // a request that errors leaves the stack as it was and reads a zero word
   function automatic stack_reply_type apply_to_stack_model(op_type op,
                                                          logic [PORT_WORD_W-1:0] value,
                                                          logic [ROLL_COUNT_W-1:0] roll_by);
      stack_reply_type        r;
      int                     top;
      int                     from;
      logic [PORT_WORD_W-1:0] moved;
      r.op   = op;
      r.word = '0;
      r.err  = ERR_OK;
      case (op)
         OP_PUSH: begin
            if (model_depth >= STACK_DEPTH) begin
               r.err = ERR_OVERFLOW;
            end else begin
               model_words[model_depth] = value;
               model_depth++;
            end
         end
         OP_POP, OP_PEEK: begin
            if (model_depth == 0) begin
               r.err = ERR_UNDERFLOW;
            end else begin
               r.word = model_words[model_depth - 1];
               if (op == OP_POP) model_depth--;
            end
         end
         default: begin
            // roll: word roll_by places below the top goes to the top,
            // the words above it each drop one place
            if (int'(roll_by) >= model_depth) begin
               r.err = ERR_ROLL_DEEP;
            end else begin
               top   = model_depth - 1;
               from  = top - int'(roll_by);
               moved = model_words[from];
               for (int k = from; k < top; k++) model_words[k] = model_words[k + 1];
               model_words[top] = moved;
            end
         end
      endcase
      r.depth = DEPTH_FIELD_W'(model_depth);
      return r;
   endfunction

   // sends one request: optional gap with valid low, then hold the payload
   // until the block takes it; valid stays high on return so back-to-back
   // requests follow without a gap
   task automatic issue_request(op_type op, logic [PORT_WORD_W-1:0] value,
                                logic [ROLL_COUNT_W-1:0] roll_by);
      int              gap;
      stack_reply_type r;
      gap = idle_on ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_push_value <= value;
      req_roll_count <= roll_by;
      do @(posedge clock); while (req_stall);
      // accepted at this edge: predict now so the order matches the block
      r = apply_to_stack_model(op, value, roll_by);
      pending_replies.push_back(r);
      request_count++;
      op_seen[int'(op)]++;
      err_seen[int'(r.err)]++;
      if (model_depth > max_depth_seen) max_depth_seen = model_depth;
   endtask

   // response side: takes each response, compares it with the oldest
   // prediction, then draws how long to stall before the next one
   initial begin : response_checker
      int              stall_left;
      stack_reply_type want;
      stall_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            stall_left = 0;
            rsp_stall <= 1'b0;
         end else if (rsp_valid && !rsp_stall) begin
            if (pending_replies.size() == 0) begin
               report_mismatch("response with no request pending", rsp_read_word, '0);
            end else begin
               want = pending_replies.pop_front();
               if (rsp_read_word !== want.word)
                  report_mismatch({want.op.name(), " read word"}, rsp_read_word, want.word);
               if (rsp_error_code !== want.err)
                  report_mismatch({want.op.name(), " error code"},
                                  64'(rsp_error_code), 64'(want.err));
               if (rsp_depth_after !== want.depth)
                  report_mismatch({want.op.name(), " depth"},
                                  64'(rsp_depth_after), 64'(want.depth));
            end
            reply_count++;
            stall_left = idle_on ? $urandom_range(0, 8) : 0;
            rsp_stall <= (stall_left != 0);
         end else if (stall_left != 0) begin
            stall_left--;
            if (stall_left == 0) rsp_stall <= 1'b0;
         end
      end
   end

   // every read and roll on an empty stack must error without touching depth
   task automatic test_empty_stack();
      issue_request(OP_POP, rand_word(), 8'd0);
      issue_request(OP_PEEK, rand_word(), 8'd0);
      issue_request(OP_ROLL, rand_word(), 8'd0);
      issue_request(OP_ROLL, rand_word(), 8'd255);
      issue_request(OP_ROLL, rand_word(), 8'($urandom_range(1, 254)));
   endtask

   // extreme words, peek, roll by zero, legal and too-deep rolls, drain to underflow
   task automatic test_basic_ops();
      issue_request(OP_PUSH, 64'h0, 8'd0);
      issue_request(OP_PUSH, '1, 8'hff);
      issue_request(OP_PUSH, 64'h8000_0000_0000_0001, 8'd0);
      issue_request(OP_PUSH, 64'h5555_aaaa_3333_cccc, 8'd0);
      issue_request(OP_PEEK, rand_word(), 8'd0);
      issue_request(OP_ROLL, rand_word(), 8'd0);  // no change
      issue_request(OP_ROLL, rand_word(), 8'd1);  // swap top two
      issue_request(OP_ROLL, rand_word(), 8'd3);  // bottom word to top
      issue_request(OP_ROLL, rand_word(), 8'd4);  // equal to depth, too deep
      issue_request(OP_PEEK, rand_word(), 8'd0);
      repeat (4) issue_request(OP_POP, rand_word(), 8'd0);
      issue_request(OP_POP, rand_word(), 8'd0);   // underflow
      issue_request(OP_PEEK, rand_word(), 8'd0);  // underflow
   endtask

   // fill with random words to full depth, then overflow and the deepest roll
   task automatic test_fill_to_overflow();
      while (model_depth < STACK_DEPTH) issue_request(OP_PUSH, rand_word(), 8'($urandom()));
      issue_request(OP_PUSH, rand_word(), 8'd0);  // overflow
      issue_request(OP_PEEK, rand_word(), 8'd0);
      issue_request(OP_ROLL, rand_word(), 8'd255);
      issue_request(OP_ROLL, rand_word(), 8'd128);
      issue_request(OP_ROLL, rand_word(), 8'd0);
      issue_request(OP_POP, rand_word(), 8'd0);
      issue_request(OP_ROLL, rand_word(), 8'd255); // equal to depth, too deep
      issue_request(OP_PUSH, rand_word(), 8'd0);
      issue_request(OP_ROLL, rand_word(), 8'd255);
   endtask

   // random request mix; shrink leans toward pops so depth walks downward
   task automatic test_random_mix(int count, bit idle, bit shrink);
      int          pick;
      int          push_limit;
      int          pop_limit;
      op_type      op;
      logic [7:0]  roll_by;
      idle_on    = idle;
      push_limit = shrink ? 20 : 35;
      pop_limit  = shrink ? 65 : 65;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < push_limit) op = OP_PUSH;
         else if (pick < pop_limit) op = OP_POP;
         else if (pick < 75) op = OP_PEEK;
         else op = OP_ROLL;
         // mostly short rolls within the stack, some at the edge, some anywhere
         pick = $urandom_range(0, 9);
         if (model_depth == 0 || pick == 0) roll_by = 8'($urandom_range(0, 255));
         else if (pick == 1) roll_by = 8'(model_depth - 1 + $urandom_range(0, 1));
         else roll_by = 8'($urandom_range(0, (model_depth > 16) ? 15 : model_depth - 1));
         issue_request(op, rand_word(), roll_by);
      end
      idle_on = 1'b1;
   endtask

   // wait until every owed response is in, bounded, then let the block settle
   task automatic wait_for_drain();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (pending_replies.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (16) @(posedge clock);
      if (pending_replies.size() != 0)
         report_mismatch("responses never received", '0, 64'(pending_replies.size()));
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_operation  <= OP_PUSH;
      req_push_value <= '0;
      req_roll_count <= '0;
      idle_on      = 1'b1;
      model_depth  = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_empty_stack();
      test_basic_ops();
      test_fill_to_overflow();
      test_random_mix(130, 1'b1, 1'b0);
      test_random_mix(130, 1'b0, 1'b1);
      wait_for_drain();

      $display("%0d requests (push %0d, pop %0d, peek %0d, roll %0d), peak depth %0d",
               request_count, op_seen[OP_PUSH], op_seen[OP_POP], op_seen[OP_PEEK],
               op_seen[OP_ROLL], max_depth_seen);
      $display("%0d responses checked; overflow %0d, underflow %0d, roll too deep %0d",
               reply_count, err_seen[ERR_OVERFLOW], err_seen[ERR_UNDERFLOW],
               err_seen[ERR_ROLL_DEEP]);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### files.f
src/wsr_pkg.sv
src/word_stack_with_roll.sv
test/testbench.sv
